FILE: src/quadrature_encoder_with_button_defines.svh
// Assertion macros shared by the encoder block.
`ifndef QUADRATURE_ENCODER_WITH_BUTTON_DEFINES_SVH
`define QUADRATURE_ENCODER_WITH_BUTTON_DEFINES_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define QEB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define QEB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QEB_ASSERT(lbl, clk, rst_n, prop, msg)
`define QEB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: src/qeb_pkg.sv
package qeb_pkg;

	// width of the configuration registers
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD = 2'd1;

	// register values after reset
	localparam logic [CFG_W-1:0] DEBOUNCE_RESET  = 24'd50000;
	localparam logic [CFG_W-1:0] LONG_HOLD_RESET = 24'd1000000;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_CW   = 2'd1,
		DIR_CCW  = 2'd2
	} dir_t;

	typedef struct packed {
		logic phase_a;
		logic phase_b;
		logic button_level;
		logic read_release;
	} sample_t;

	typedef struct packed {
		dir_t direction;
		logic pressed;
		logic held_long;
		logic released;
	} result_t;

	// button status for one tick, from the debouncer to the top level
	typedef struct packed {
		logic pressed;
		logic held_long;
		logic released;
	} button_status_t;

	// Gray sequence 00 -> 01 -> 11 -> 10 -> 00 is clockwise
	function automatic dir_t decode_step(logic [1:0] from, logic [1:0] to);
		logic [1:0] cw_next;
		logic [1:0] ccw_next;
		case (from)
			2'b00: begin
				cw_next  = 2'b01;
				ccw_next = 2'b10;
			end
			2'b01: begin
				cw_next  = 2'b11;
				ccw_next = 2'b00;
			end
			2'b10: begin
				cw_next  = 2'b00;
				ccw_next = 2'b11;
			end
			default: begin
				cw_next  = 2'b10;
				ccw_next = 2'b01;
			end
		endcase
		if (to == cw_next)
			return DIR_CW;
		else if (to == ccw_next)
			return DIR_CCW;
		else
			return DIR_NONE;
	endfunction

endpackage

FILE: src/quadrature_encoder_with_button.sv
// A sample transfer reaches its result through the input stage and then the result stage.
// Throughput: one sample per cycle; the only stall comes from a stalled result with both
// the input stage and the result register full.
// Reset (arst_n low): phase history unprimed, button released, counters and release latch
// cleared, debounce_ticks = 50000 and long_hold_ticks = 1000000.
`include "quadrature_encoder_with_button_defines.svh"

module quadrature_encoder_with_button #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  qeb_pkg::sample_t              sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output qeb_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [qeb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [qeb_pkg::CFG_W-1:0]     cfg_data
);

	logic [qeb_pkg::CFG_W-1:0] debounce_q;
	logic [qeb_pkg::CFG_W-1:0] long_hold_q;

	qeb_pkg::sample_t          sample_s1;
	logic                      valid_s1;
	logic [1:0]                last_phase_q;
	logic                      primed_q;
	qeb_pkg::result_t          result_q;
	logic                      result_valid_q;

	logic                      out_load;
	logic                      step;
	logic [1:0]                phase;
	qeb_pkg::dir_t             direction;
	qeb_pkg::button_status_t   button;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= qeb_pkg::DEBOUNCE_RESET;
			long_hold_q <= qeb_pkg::LONG_HOLD_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				qeb_pkg::CFG_DEBOUNCE:  debounce_q  <= cfg_data;
				qeb_pkg::CFG_LONG_HOLD: long_hold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// the result register loads when empty or drained this cycle
	assign out_load     = !result_valid_q || !result_stall;
	assign step         = valid_s1 && out_load;
	assign sample_stall = valid_s1 && !out_load;

	// input stage: hold while the result side is blocked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!sample_stall)
			valid_s1 <= sample_valid;
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall)
			sample_s1 <= sample;
	end

	// decode the phase step against the last pair
	assign phase = {sample_s1.phase_a, sample_s1.phase_b};

	always_comb begin
		if (primed_q && (phase != last_phase_q))
			direction = qeb_pkg::decode_step(last_phase_q, phase);
		else
			direction = qeb_pkg::DIR_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_phase_q <= 2'b00;
			primed_q     <= 1'b0;
		end else if (step) begin
			last_phase_q <= phase;
			primed_q     <= 1'b1;
		end
	end

	qeb_button #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_button (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.raw_pressed    (!sample_s1.button_level),
		.do_read        (sample_s1.read_release),
		.debounce_ticks (debounce_q),
		.long_hold_ticks(long_hold_q),
		.status         (button)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (out_load)
			result_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q.direction <= direction;
			result_q.pressed   <= button.pressed;
			result_q.held_long <= button.held_long;
			result_q.released  <= button.released;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`QEB_ASSERT(a_s1_holds, clk, arst_n, valid_s1 && !out_load |=> valid_s1 && $stable(sample_s1), "input stage lost a blocked sample")
	`QEB_ASSERT(a_first_no_step, clk, arst_n, step && !primed_q |=> result.direction == qeb_pkg::DIR_NONE, "unprimed sample reported a step")
	`QEB_ASSERT(a_long_needs_press, clk, arst_n, result_valid && result.held_long |-> result.pressed, "long hold without press")
	`QEB_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !result_valid && !valid_s1, "pipeline valid during reset")

endmodule

FILE: src/qeb_button.sv
`include "quadrature_encoder_with_button_defines.svh"

module qeb_button #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       raw_pressed,
	input  logic                       do_read,
	input  logic [qeb_pkg::CFG_W-1:0]  debounce_ticks,
	input  logic [qeb_pkg::CFG_W-1:0]  long_hold_ticks,
	output qeb_pkg::button_status_t    status
);

	localparam int CMP_W = (COUNT_WIDTH > qeb_pkg::CFG_W) ? COUNT_WIDTH : qeb_pkg::CFG_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic                   button_q;
	logic [COUNT_WIDTH-1:0] disagree_q;
	logic [COUNT_WIDTH-1:0] hold_q;
	logic                   latch_q;

	logic                   button_n;
	logic [COUNT_WIDTH-1:0] disagree_n;
	logic [COUNT_WIDTH-1:0] hold_n;
	logic                   latch_n;

	logic                   disagree;
	logic                   take;
	logic                   latch_set;
	logic [COUNT_WIDTH-1:0] disagree_inc;
	logic [COUNT_WIDTH-1:0] hold_inc;

	// saturating counter steps; the hold count advances only while pressed
	assign disagree_inc = (disagree_q == CNT_MAX) ? disagree_q : disagree_q + COUNT_WIDTH'(1);
	assign hold_inc     = !button_q ? hold_q :
	                      (hold_q == CNT_MAX) ? hold_q : hold_q + COUNT_WIDTH'(1);

	// take the raw level once disagreement outlasts the debounce window
	assign disagree = raw_pressed != button_q;
	assign take     = disagree && (CMP_W'(disagree_inc) > CMP_W'(debounce_ticks));

	always_comb begin
		button_n   = take ? raw_pressed : button_q;
		disagree_n = (disagree && !take) ? disagree_inc : '0;
		hold_n     = take ? '0 : hold_inc;
		latch_set  = latch_q | (take & ~raw_pressed);
		latch_n    = do_read ? 1'b0 : latch_set;

		status.pressed   = button_n;
		status.held_long = button_n && (CMP_W'(hold_n) >= CMP_W'(long_hold_ticks));
		status.released  = do_read & latch_set;
	end

	// advance the button state once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_q   <= 1'b0;
			disagree_q <= '0;
			hold_q     <= '0;
			latch_q    <= 1'b0;
		end else if (step) begin
			button_q   <= button_n;
			disagree_q <= disagree_n;
			hold_q     <= hold_n;
			latch_q    <= latch_n;
		end
	end

	`QEB_ASSERT(a_button_holds_idle, clk, arst_n, !step |=> $stable(button_q) && $stable(latch_q), "button state moved without a tick")
	`QEB_ASSERT(a_read_clears_latch, clk, arst_n, step && do_read |=> !latch_q, "release latch survived a read")
	`QEB_ASSERT(a_hold_zero_released, clk, arst_n, !button_q |-> hold_q == '0, "hold count running while released")

endmodule

FILE: test/tb_quadrature_encoder_with_button.sv
`timescale 1ns / 100ps

module tb_quadrature_encoder_with_button;

	localparam int CNT_W           = 24;
	localparam int STALL_LIMIT     = 4000;
	localparam int HOLD_OFF_CYCLES = 64;
	localparam int DRAIN_CYCLES    = 4;
	localparam logic [qeb_pkg::CFG_W-1:0] CFG_MAX = '1;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                 kind;
		qeb_pkg::sample_t          pins;
		bit                        typed;
		qeb_pkg::result_t          want;
		logic [qeb_pkg::CFG_W-1:0] debounce;
		logic [qeb_pkg::CFG_W-1:0] long_hold;
	} script_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          sample_valid;
	logic                          sample_stall;
	qeb_pkg::sample_t              sample;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	qeb_pkg::result_t              result;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [qeb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [qeb_pkg::CFG_W-1:0]     cfg_data;

	// encoder and button state as the block should hold it
	logic [1:0]                enc_last          = 2'b00;
	bit                        enc_primed        = 1'b0;
	bit                        btn_down          = 1'b0;
	logic [CNT_W-1:0]          btn_disagree      = '0;
	logic [CNT_W-1:0]          btn_hold          = '0;
	bit                        btn_release_latch = 1'b0;
	logic [qeb_pkg::CFG_W-1:0] debounce_q        = qeb_pkg::DEBOUNCE_RESET;
	logic [qeb_pkg::CFG_W-1:0] long_hold_q       = qeb_pkg::LONG_HOLD_RESET;

	qeb_pkg::result_t pending_status[$];
	script_row_t      script[$];

	int unsigned mismatch_count = 0;
	int unsigned idle_cycles    = 0;
	int unsigned sender_pct     = 0;
	int unsigned stall_pct      = 0;
	int unsigned hold_off_seq   = 0;
	int unsigned hold_off_seen  = 0;
	int unsigned hold_off_left  = 0;

	// knob and finger model for the random part
	logic [1:0]  knob_pos    = 2'b00;
	bit          finger_down = 1'b0;
	int unsigned seg_left    = 0;

	quadrature_encoder_with_button #(.COUNT_WIDTH(CNT_W)) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// map between pin pair and position along the clockwise cycle; the map is its own inverse
	function automatic logic [1:0] gray_map(input logic [1:0] v);
		return {v[1], v[1] ^ v[0]};
	endfunction

	function automatic logic [CNT_W-1:0] sat_step(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// advance the encoder and button state by one tick and return the status it reports
	function automatic qeb_pkg::result_t next_status(input qeb_pkg::sample_t s);
		qeb_pkg::result_t r;
		logic [1:0]       ab;
		logic [1:0]       delta;
		ab = {s.phase_a, s.phase_b};
		r = '0;
		r.direction = qeb_pkg::DIR_NONE;
		if (!enc_primed) begin
			enc_last = ab;
			enc_primed = 1'b1;
		end else if (ab != enc_last) begin
			delta = gray_map(ab) - gray_map(enc_last);
			case (delta)
				2'd1:    r.direction = qeb_pkg::DIR_CW;
				2'd3:    r.direction = qeb_pkg::DIR_CCW;
				default: r.direction = qeb_pkg::DIR_NONE;
			endcase
			enc_last = ab;
		end

		if (btn_down)
			btn_hold = sat_step(btn_hold);

		// accept the pin level once it has disagreed for more than the debounce time
		if (!s.button_level != btn_down) begin
			btn_disagree = sat_step(btn_disagree);
			if (btn_disagree > debounce_q) begin
				btn_down = !s.button_level;
				btn_disagree = '0;
				btn_hold = '0;
				if (!btn_down)
					btn_release_latch = 1'b1;
			end
		end else begin
			btn_disagree = '0;
		end

		if (s.read_release) begin
			r.released = btn_release_latch;
			btn_release_latch = 1'b0;
		end
		r.pressed = btn_down;
		r.held_long = btn_down && (btn_hold >= long_hold_q);
		return r;
	endfunction

	function automatic void add_tick(input logic [3:0] pins, input bit typed,
			input qeb_pkg::result_t want);
		script_row_t row;
		row.kind = ROW_TICK;
		row.pins = pins;
		row.typed = typed;
		row.want = want;
		row.debounce = '0;
		row.long_hold = '0;
		script.push_back(row);
	endfunction

	function automatic void add_cfg(input logic [qeb_pkg::CFG_W-1:0] deb,
			input logic [qeb_pkg::CFG_W-1:0] hold);
		script_row_t row;
		row.kind = ROW_CFG;
		row.pins = '0;
		row.typed = 1'b0;
		row.want = '0;
		row.debounce = deb;
		row.long_hold = hold;
		script.push_back(row);
	endfunction

	// offer one sample, hold it until the transfer, then queue its status
	task automatic send_tick(input qeb_pkg::sample_t s, input bit typed,
			input qeb_pkg::result_t want);
		qeb_pkg::result_t predicted;
		while ($urandom_range(99) < sender_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
		predicted = next_status(s);
		pending_status.push_back(typed ? want : predicted);
	endtask

	// drop valid and wait until every status is back and the pipeline is empty
	task automatic drain_results();
		sample_valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [qeb_pkg::CFG_W-1:0] deb,
			input logic [qeb_pkg::CFG_W-1:0] hold);
		cfg_valid <= 1'b1;
		cfg_index <= qeb_pkg::CFG_DEBOUNCE;
		cfg_data <= deb;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= qeb_pkg::CFG_LONG_HOLD;
		cfg_data <= hold;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		debounce_q = deb;
		long_hold_q = hold;
	endtask

	// turn the knob mostly by legal steps and press with bounce; mix in some raw noise
	task automatic run_random(input int unsigned count, input int unsigned seg_max);
		qeb_pkg::sample_t s;
		repeat (count) begin
			if ($urandom_range(9) == 0) begin
				s = 4'($urandom_range(15));
				knob_pos = gray_map({s.phase_a, s.phase_b});
			end else begin
				case ($urandom_range(9))
					0, 1, 2, 3: knob_pos = knob_pos + 2'd1;
					4, 5, 6:    knob_pos = knob_pos - 2'd1;
					7:          knob_pos = knob_pos + 2'd2;
					default:    ;
				endcase
				if (seg_left == 0) begin
					finger_down = !finger_down;
					seg_left = $urandom_range(seg_max, 1);
				end
				seg_left--;
				{s.phase_a, s.phase_b} = gray_map(knob_pos);
				s.button_level = !(finger_down ^ ($urandom_range(99) < 12));
				s.read_release = ($urandom_range(3) == 0);
			end
			send_tick(s, 1'b0, '0);
		end
	endtask

	// stall the result side at random, or hold it off for a long stretch on request
	always @(posedge clk) begin
		if (hold_off_seq != hold_off_seen) begin
			hold_off_seen <= hold_off_seq;
			hold_off_left <= HOLD_OFF_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_off_left != 0) begin
			hold_off_left <= hold_off_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// compare each result transfer with the oldest queued status
	always @(posedge clk) begin : check_result
		qeb_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_status.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result: dir %0d prs %b hold %b rel %b", $time,
						result.direction, result.pressed, result.held_long, result.released);
			end else begin
				want = pending_status.pop_front();
				if (result.direction !== want.direction || result.pressed !== want.pressed ||
						result.held_long !== want.held_long ||
						result.released !== want.released) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: want dir %0d prs %b hold %b rel %b, got dir %0d prs %b hold %b rel %b",
							$time, want.direction, want.pressed, want.held_long, want.released,
							result.direction, result.pressed, result.held_long, result.released);
				end
			end
		end
	end

	// end the run when nothing has moved for too long
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("** quadrature_encoder_with_button: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		script_row_t               row;
		logic [qeb_pkg::CFG_W-1:0] deb;
		logic [qeb_pkg::CFG_W-1:0] hold;
		int unsigned               seg_max;

		arst_n = 1'b1;
		sample_valid = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		cfg_index = qeb_pkg::CFG_DEBOUNCE;
		cfg_data = '0;

		// reset settings: the first tick only primes the phase history
		add_tick(4'b1110, 1'b1, '{qeb_pkg::DIR_NONE, 1'b0, 1'b0, 1'b0});
		add_tick(4'b1010, 1'b1, '{qeb_pkg::DIR_CW, 1'b0, 1'b0, 1'b0});
		add_tick(4'b1110, 1'b1, '{qeb_pkg::DIR_CCW, 1'b0, 1'b0, 1'b0});
		// both phases change at once: no step, pair still adopted
		add_tick(4'b0010, 1'b1, '{qeb_pkg::DIR_NONE, 1'b0, 1'b0, 1'b0});
		add_tick(4'b0111, 1'b1, '{qeb_pkg::DIR_CW, 1'b0, 1'b0, 1'b0});
		add_tick(4'b0101, 1'b1, '{qeb_pkg::DIR_NONE, 1'b0, 1'b0, 1'b0});
		// zero debounce and hold: press is taken and held at once
		add_cfg('0, '0);
		add_tick(4'b0000, 1'b1, '{qeb_pkg::DIR_CCW, 1'b1, 1'b1, 1'b0});
		// release accepted and read on the same tick
		add_tick(4'b1011, 1'b1, '{qeb_pkg::DIR_CCW, 1'b0, 1'b0, 1'b1});
		add_tick(4'b1111, 1'b1, '{qeb_pkg::DIR_CCW, 1'b0, 1'b0, 1'b0});
		// largest debounce: the press is never taken
		add_cfg(CFG_MAX, CFG_MAX);
		add_tick(4'b1100, 1'b1, '{qeb_pkg::DIR_NONE, 1'b0, 1'b0, 1'b0});
		add_tick(4'b1100, 1'b1, '{qeb_pkg::DIR_NONE, 1'b0, 1'b0, 1'b0});
		add_tick(4'b1100, 1'b1, '{qeb_pkg::DIR_NONE, 1'b0, 1'b0, 1'b0});
		// short debounce and hold: press, reach long hold, release, bounce, read
		add_cfg(24'd2, 24'd3);
		add_tick(4'b0100, 1'b0, '0);
		add_tick(4'b1100, 1'b0, '0);
		add_tick(4'b1000, 1'b0, '0);
		add_tick(4'b0000, 1'b0, '0);
		add_tick(4'b0100, 1'b0, '0);
		add_tick(4'b0101, 1'b0, '0);
		add_tick(4'b0110, 1'b0, '0);
		add_tick(4'b0010, 1'b0, '0);
		add_tick(4'b0010, 1'b0, '0);
		add_tick(4'b0000, 1'b0, '0);
		add_tick(4'b0011, 1'b0, '0);
		add_tick(4'b1011, 1'b0, '0);

		// assert reset after time zero so every flop sees the falling edge
		#0.5;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (script[i]) begin
			row = script[i];
			if (row.kind == ROW_CFG) begin
				drain_results();
				write_cfg(row.debounce, row.long_hold);
			end else begin
				send_tick(row.pins, row.typed, row.want);
			end
		end

		// random phases over several settings and idling patterns
		for (int ph = 0; ph < 8; ph++) begin
			drain_results();
			case (ph)
				0: begin
					deb = '0;
					hold = '0;
				end
				1: begin
					deb = CFG_MAX;
					hold = CFG_MAX;
				end
				5: begin
					deb = 24'd1;
					hold = CFG_MAX;
				end
				7: begin
					deb = 24'($urandom_range(30, 10));
					hold = 24'($urandom_range(150, 50));
				end
				default: begin
					deb = 24'($urandom_range(6));
					hold = 24'($urandom_range(40));
				end
			endcase
			write_cfg(deb, hold);
			case (ph % 4)
				0: begin
					sender_pct = 0;
					stall_pct = 0;
				end
				1: begin
					sender_pct = 53;
					stall_pct = 0;
				end
				2: begin
					sender_pct = 0;
					stall_pct = 53;
				end
				default: begin
					sender_pct = 25;
					stall_pct = 25;
				end
			endcase
			seg_max = ((deb > 1000) ? 30 : 2 * deb + 10) + ((hold > 200) ? 20 : hold + 5);
			run_random(190, seg_max);
		end

		// hold off the result side while samples keep coming, so the input stalls
		drain_results();
		sender_pct = 0;
		stall_pct = 0;
		hold_off_seq <= hold_off_seq + 1;
		run_random(120, 40);

		// pause the sender until every status is back, then go on
		drain_results();
		run_random(40, 40);

		drain_results();
		if (mismatch_count == 0)
			$display("** quadrature_encoder_with_button: PASSED **");
		else
			$display("** quadrature_encoder_with_button: FAILED **");
		$finish;
	end

endmodule
